FILE: hdl/mcs_pkg.sv
// shared types and constants of the motor CAN command sequencer
`timescale 1ns / 1ps

package mcs_pkg;

	localparam int NUM_SPEED_IN = 3;
	localparam int CFG_IDX_W    = 1;

	typedef logic [NUM_SPEED_IN-1:0][31:0] speed_arr_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FIRST_ID = 1'b0,
		CFG_REFRESH  = 1'b1
	} cfg_reg_t;

	localparam logic [3:0]  FIRST_ID_RST = 4'd1;
	localparam logic [15:0] REFRESH_RST  = 16'd500;

	typedef enum logic [2:0] {
		FK_MODE,
		FK_ENABLE,
		FK_SPEED,
		FK_ZERO,
		FK_DISABLE
	} frame_kind_t;

	typedef struct packed {
		logic        valid;
		logic        active;
		frame_kind_t kind;
	} plan_t;

	localparam logic [10:0] MODE_FRAME_ID = 11'h7FF;
	localparam logic [10:0] MOTOR_ID_BASE = 11'h200;
	localparam logic [7:0]  MODE_BYTE2    = 8'h55;
	localparam logic [7:0]  MODE_BYTE3    = 8'h0A;
	localparam logic [7:0]  MODE_BYTE4    = 8'h03;
	localparam logic [63:0] ENABLE_DATA   = 64'hFCFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] DISABLE_DATA  = 64'hFDFF_FFFF_FFFF_FFFF;
	localparam logic [3:0]  LEN_SPEED     = 4'd4;
	localparam logic [3:0]  LEN_FULL      = 4'd8;

endpackage

FILE: hdl/mcs_ctrl.sv
// input register, armed and refresh state, per-update frame plan
`timescale 1ns / 1ps

module mcs_ctrl import mcs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        armed,
	input  logic [31:0] now_ms,
	input  speed_arr_t  speeds,
	input  logic [15:0] refresh_ms,
	input  logic        plan_take,
	output plan_t       plan,
	output speed_arr_t  speeds_s1
);

	logic        valid_s1;
	logic        armed_s1;
	logic [31:0] now_s1;
	logic        was_armed_q;
	logic [31:0] last_enable_q;
	logic [31:0] age;
	logic        burst;
	logic        in_accept;

	assign in_ready  = !valid_s1 || plan_take;
	assign in_accept = in_valid && in_ready;

	// modular age since the last enable burst
	assign age   = now_s1 - last_enable_q;
	assign burst = armed_s1 && (!was_armed_q || (age > {16'd0, refresh_ms}));

	always_comb begin
		plan.valid  = valid_s1;
		plan.active = armed_s1 || was_armed_q;
		if (burst) begin
			plan.kind = FK_MODE;
		end else if (armed_s1) begin
			plan.kind = FK_SPEED;
		end else begin
			plan.kind = FK_ZERO;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			was_armed_q   <= 1'b0;
			last_enable_q <= '0;
		end else begin
			if (in_accept) begin
				valid_s1 <= 1'b1;
			end else if (plan_take) begin
				valid_s1 <= 1'b0;
			end
			if (plan_take) begin
				was_armed_q <= armed_s1;
				if (burst) begin
					last_enable_q <= now_s1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			armed_s1  <= armed;
			now_s1    <= now_ms;
			speeds_s1 <= speeds;
		end
	end

endmodule

FILE: hdl/mcs_emit.sv
// frame sequencer and output register, one frame per cycle unless out_ready stalls the output
`timescale 1ns / 1ps

module mcs_emit import mcs_pkg::*; #(
	parameter int NUM_MOTORS = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  plan_t       plan,
	input  speed_arr_t  speeds,
	input  logic [3:0]  first_motor_id,
	output logic        plan_take,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [10:0] frame_id,
	output logic [3:0]  frame_len,
	output logic [63:0] frame_data,
	output logic        last_frame
);

	localparam int MW = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;

	logic              busy_q, busy_d;
	frame_kind_t       kind_q, kind_d;
	logic [MW-1:0]     mot_q, mot_d;
	speed_arr_t        speed_q;
	logic              out_free;
	logic              emit;
	logic              seg_end;
	logic              frame_end;
	logic [10:0]       motor_id;
	logic [31:0]       speed_sel;
	logic [10:0]       id_d;
	logic [3:0]        len_d;
	logic [63:0]       data_d;

	assign out_free  = !out_valid || out_ready;
	assign emit      = busy_q && out_free;
	assign seg_end   = (mot_q == MW'(NUM_MOTORS - 1));
	assign frame_end = seg_end && ((kind_q == FK_SPEED) || (kind_q == FK_DISABLE));
	// next plan enters as the last frame of the current update leaves
	assign plan_take = plan.valid && (!busy_q || (emit && frame_end));

	assign motor_id = {7'd0, first_motor_id} + 11'(mot_q);

	// motors past the speed inputs get zero speed
	always_comb begin
		speed_sel = '0;
		for (int j = 0; j < NUM_SPEED_IN; j++) begin
			if (int'(mot_q) == j) begin
				speed_sel = speed_q[j];
			end
		end
	end

	always_comb begin
		id_d   = MOTOR_ID_BASE + motor_id;
		len_d  = LEN_FULL;
		data_d = '0;
		case (kind_q)
			FK_MODE: begin
				id_d   = MODE_FRAME_ID;
				data_d = {24'd0, MODE_BYTE4, MODE_BYTE3, MODE_BYTE2, 5'd0, motor_id[10:8],
					motor_id[7:0]};
			end
			FK_ENABLE: begin
				data_d = ENABLE_DATA;
			end
			FK_SPEED: begin
				len_d  = LEN_SPEED;
				data_d = {32'd0, speed_sel};
			end
			FK_ZERO: begin
				len_d  = LEN_SPEED;
			end
			FK_DISABLE: begin
				data_d = DISABLE_DATA;
			end
			default: begin
				data_d = '0;
			end
		endcase
	end

	always_comb begin
		busy_d = busy_q;
		kind_d = kind_q;
		mot_d  = mot_q;
		if (emit) begin
			if (seg_end) begin
				mot_d = '0;
				case (kind_q)
					FK_MODE:   kind_d = FK_ENABLE;
					FK_ENABLE: kind_d = FK_SPEED;
					FK_ZERO:   kind_d = FK_DISABLE;
					default:   busy_d = 1'b0;
				endcase
			end else begin
				mot_d = mot_q + 1'b1;
			end
		end
		if (plan_take) begin
			busy_d = plan.active;
			kind_d = plan.kind;
			mot_d  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			kind_q    <= FK_SPEED;
			mot_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			busy_q <= busy_d;
			kind_q <= kind_d;
			mot_q  <= mot_d;
			if (emit) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (plan_take) begin
			speed_q <= speeds;
		end
		if (emit) begin
			frame_id   <= id_d;
			frame_len  <= len_d;
			frame_data <= data_d;
			last_frame <= frame_end;
		end
	end

endmodule

FILE: hdl/motor_can_command_sequencer_top.sv
// top level of the motor CAN command sequencer
`timescale 1ns / 1ps

// Takes one control update per request and sends the CAN frames it causes, one frame
// per cycle on the output channel unless out_ready stalls it. An update is registered
// on entry and can be taken every cycle while the input register is free; the frame
// sequencer then holds it while it emits its frames: 3*NUM_MOTORS for an enable burst
// (mode writes, enables, speeds), NUM_MOTORS for a plain speed update and 2*NUM_MOTORS
// on disarm (zero speeds, disables), so 9, 3 and 6 frames with three motors. The next
// update moves into the sequencer in the cycle its predecessor's last frame is
// registered, so frames of back-to-back updates leave without gaps; an update that
// causes no frame only passes the input register. Configuration writes complete at
// once and must only be made while no frame is pending.

module motor_can_command_sequencer_top import mcs_pkg::*; #(
	parameter int NUM_MOTORS = 3
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 armed,
	input  logic [31:0]          now_ms,
	input  logic [31:0]          speed_0,
	input  logic [31:0]          speed_1,
	input  logic [31:0]          speed_2,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [10:0]          frame_id,
	output logic [3:0]           frame_len,
	output logic [63:0]          frame_data,
	output logic                 last_frame
);

	logic [3:0]  first_motor_id_q;
	logic [15:0] refresh_ms_q;
	plan_t       plan;
	logic        plan_take;
	speed_arr_t  speeds_s1;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_motor_id_q <= FIRST_ID_RST;
			refresh_ms_q     <= REFRESH_RST;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				CFG_FIRST_ID: first_motor_id_q <= cfg_data[3:0];
				CFG_REFRESH:  refresh_ms_q     <= cfg_data;
				default:      first_motor_id_q <= first_motor_id_q;
			endcase
		end
	end

	mcs_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.armed      (armed),
		.now_ms     (now_ms),
		.speeds     ({speed_2, speed_1, speed_0}),
		.refresh_ms (refresh_ms_q),
		.plan_take  (plan_take),
		.plan       (plan),
		.speeds_s1  (speeds_s1)
	);

	mcs_emit #(
		.NUM_MOTORS (NUM_MOTORS)
	) u_emit (
		.clk            (clk),
		.arst_n         (arst_n),
		.plan           (plan),
		.speeds         (speeds_s1),
		.first_motor_id (first_motor_id_q),
		.plan_take      (plan_take),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.frame_id       (frame_id),
		.frame_len      (frame_len),
		.frame_data     (frame_data),
		.last_frame     (last_frame)
	);

endmodule

FILE: hdl/mcs_checker.sv
// port-level checks of the sequencer output, bound to the top level
`timescale 1ns / 1ps

module mcs_checker import mcs_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [10:0] frame_id,
	input logic [3:0]  frame_len,
	input logic [63:0] frame_data,
	input logic        last_frame
);

	// a stalled frame holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(frame_data) && $stable(frame_id)
			&& $stable(frame_len) && $stable(last_frame))
		else $error("stalled frame changed");

	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (frame_len == LEN_SPEED) || (frame_len == LEN_FULL))
		else $error("bad frame length");

	// speed frames carry only four bytes
	a_short_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (frame_len == LEN_SPEED) |-> (frame_data[63:32] == 32'd0))
		else $error("short frame with upper bytes set");

	// a mode write is a full-length frame with the mode byte and never the final frame of an update
	a_mode_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (frame_id == MODE_FRAME_ID) |-> (frame_len == LEN_FULL)
			&& (frame_data[23:16] == MODE_BYTE2) && !last_frame)
		else $error("malformed mode write");

endmodule

bind motor_can_command_sequencer_top mcs_checker u_mcs_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.frame_id   (frame_id),
	.frame_len  (frame_len),
	.frame_data (frame_data),
	.last_frame (last_frame)
);

FILE: dv/tb_motor_can_command_sequencer_top.sv
// testbench for the motor CAN command sequencer: directed, back-pressure and random traffic
`timescale 1ns / 1ps

module tb_motor_can_command_sequencer_top;
	import mcs_pkg::*;

	localparam int MOTORS         = 3;
	localparam int DRAIN_CYCLES   = 8;
	localparam int TIMEOUT_CYCLES = 500_000;

	typedef struct packed {
		logic       armed;
		logic [31:0] now_ms;
		speed_arr_t speed;
	} ctrl_update_t;

	typedef struct packed {
		logic [10:0] id;
		logic [3:0]  len;
		logic [63:0] data;
		logic        last;
	} can_frame_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid;
	logic        cfg_ready;
	cfg_reg_t    cfg_index;
	logic [15:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic        armed;
	logic [31:0] now_ms;
	logic [31:0] speed_0;
	logic [31:0] speed_1;
	logic [31:0] speed_2;
	logic        out_valid;
	logic        out_ready;
	logic [10:0] frame_id;
	logic [3:0]  frame_len;
	logic [63:0] frame_data;
	logic        last_frame;

	// mirror of the block state and registers
	logic [3:0]  cfg_first_id   = FIRST_ID_RST;
	logic [15:0] cfg_refresh    = REFRESH_RST;
	logic        was_armed_q    = 1'b0;
	logic [31:0] last_enable_ms = '0;

	can_frame_t expected_frames[$];
	int  errors = 0;
	bit  tx_idle = 1'b1;
	bit  rx_idle = 1'b1;
	int  long_hold = 0;

	motor_can_command_sequencer_top #(.NUM_MOTORS(MOTORS)) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.armed      (armed),
		.now_ms     (now_ms),
		.speed_0    (speed_0),
		.speed_1    (speed_1),
		.speed_2    (speed_2),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.frame_id   (frame_id),
		.frame_len  (frame_len),
		.frame_data (frame_data),
		.last_frame (last_frame)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#(TIMEOUT_CYCLES * 10);
		$display("RESULT: ERROR");
		$finish;
	end

	task automatic report_error(input string msg);
		errors++;
		if (errors <= 10)
			$display("%0t: %s", $realtime, msg);
	endtask

	function automatic logic [10:0] motor_can_id(input int i);
		return 11'(cfg_first_id) + 11'(i);
	endfunction

	function automatic can_frame_t mk_frame(input logic [10:0] id, input logic [3:0] len,
			input logic [63:0] data);
		can_frame_t f;
		f.id   = id;
		f.len  = len;
		f.data = data;
		f.last = 1'b0;
		return f;
	endfunction

	// computes the frames of one accepted update and queues them
	function automatic int predict_frames(input ctrl_update_t u);
		can_frame_t  burst[$];
		logic [31:0] age;
		logic [31:0] sp;
		logic [10:0] mid;
		int          i;
		if (u.armed) begin
			age = u.now_ms - last_enable_ms;
			if (!was_armed_q || age > {16'd0, cfg_refresh}) begin
				for (i = 0; i < MOTORS; i++) begin
					mid = motor_can_id(i);
					burst.push_back(mk_frame(MODE_FRAME_ID, LEN_FULL, {24'd0, MODE_BYTE4,
						MODE_BYTE3, MODE_BYTE2, 5'd0, mid[10:8], mid[7:0]}));
				end
				for (i = 0; i < MOTORS; i++)
					burst.push_back(mk_frame(MOTOR_ID_BASE + motor_can_id(i), LEN_FULL,
						ENABLE_DATA));
				last_enable_ms = u.now_ms;
			end
			for (i = 0; i < MOTORS; i++) begin
				// motors without a speed input get zero
				sp = (i < NUM_SPEED_IN) ? u.speed[i] : '0;
				burst.push_back(mk_frame(MOTOR_ID_BASE + motor_can_id(i), LEN_SPEED,
					{32'd0, sp}));
			end
		end else if (was_armed_q) begin
			for (i = 0; i < MOTORS; i++)
				burst.push_back(mk_frame(MOTOR_ID_BASE + motor_can_id(i), LEN_SPEED, '0));
			for (i = 0; i < MOTORS; i++)
				burst.push_back(mk_frame(MOTOR_ID_BASE + motor_can_id(i), LEN_FULL,
					DISABLE_DATA));
		end
		was_armed_q = u.armed;
		if (burst.size() > 0)
			burst[burst.size() - 1].last = 1'b1;
		foreach (burst[i])
			expected_frames.push_back(burst[i]);
		return burst.size();
	endfunction

	function automatic ctrl_update_t mk_update(input logic a, input logic [31:0] t,
			input logic [31:0] s0, input logic [31:0] s1, input logic [31:0] s2);
		ctrl_update_t u;
		u.armed    = a;
		u.now_ms   = t;
		u.speed[0] = s0;
		u.speed[1] = s1;
		u.speed[2] = s2;
		return u;
	endfunction

	function automatic logic [31:0] pick_speed();
		case ($urandom_range(0, 7))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'h3F00_0000;
			default: return $urandom;
		endcase
	endfunction

	// leaves in_valid high on return; the caller sends again or drains in the same step
	task automatic send_update(input ctrl_update_t u, output int n_frames);
		int gap;
		gap = tx_idle ? $urandom_range(0, 11) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		armed    <= u.armed;
		now_ms   <= u.now_ms;
		speed_0  <= u.speed[0];
		speed_1  <= u.speed[1];
		speed_2  <= u.speed[2];
		@(negedge clk);
		while (!in_ready) @(negedge clk);
		@(posedge clk);
		n_frames = predict_frames(u);
	endtask

	task automatic send(input ctrl_update_t u);
		int n;
		send_update(u, n);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_frames.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		while (!cfg_ready) @(negedge clk);
		@(posedge clk);
		case (idx)
			CFG_FIRST_ID: cfg_first_id = data[3:0];
			CFG_REFRESH:  cfg_refresh  = data;
			default: ;
		endcase
	endtask

	task automatic configure(input logic [15:0] id_word, input logic [15:0] refresh_word);
		wait_idle();
		write_reg(CFG_FIRST_ID, id_word);
		write_reg(CFG_REFRESH, refresh_word);
		cfg_valid <= 1'b0;
	endtask

	task automatic test_reset_defaults();
		send(mk_update(1'b0, 32'd0, '0, '0, '0));
		send(mk_update(1'b1, 32'hFFFF_FFFF, '0, '0, '0));
		send(mk_update(1'b1, 32'd499, 32'hFFFF_FFFF, 32'h3F00_0000, 32'h8000_0000));
		send(mk_update(1'b1, 32'd500, $urandom, $urandom, $urandom));
		send(mk_update(1'b1, 32'd1000, $urandom, $urandom, $urandom));
		// time going backwards wraps to a large age
		send(mk_update(1'b1, 32'd100, $urandom, $urandom, $urandom));
		send(mk_update(1'b0, 32'd200, $urandom, $urandom, $urandom));
		send(mk_update(1'b0, 32'd300, $urandom, $urandom, $urandom));
		send(mk_update(1'b1, 32'd100, 32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF));
		send(mk_update(1'b0, 32'd150, '0, '0, '0));
	endtask

	task automatic test_config_extremes();
		configure(16'hFFFF, 16'hFFFF);
		send(mk_update(1'b1, 32'h8000_0000, $urandom, $urandom, $urandom));
		send(mk_update(1'b1, 32'h8000_FFFF, $urandom, $urandom, $urandom));
		send(mk_update(1'b1, 32'h8001_0000, $urandom, $urandom, $urandom));
		send(mk_update(1'b0, 32'h8001_0001, $urandom, $urandom, $urandom));
		// upper data bits are dropped by the id register
		configure(16'hFFF0, 16'h0001);
		send(mk_update(1'b1, 32'd5, $urandom, $urandom, $urandom));
		send(mk_update(1'b1, 32'd6, $urandom, $urandom, $urandom));
		send(mk_update(1'b1, 32'd7, $urandom, $urandom, $urandom));
		send(mk_update(1'b0, 32'd8, $urandom, $urandom, $urandom));
		// zero interval: burst on any change of time
		configure(16'h0007, 16'h0000);
		send(mk_update(1'b1, 32'd9, $urandom, $urandom, $urandom));
		send(mk_update(1'b1, 32'd9, $urandom, $urandom, $urandom));
		send(mk_update(1'b1, 32'd10, $urandom, $urandom, $urandom));
		send(mk_update(1'b0, 32'd11, $urandom, $urandom, $urandom));
	endtask

	task automatic test_backpressure();
		logic [31:0] t;
		int          i;
		configure(16'h0003, 16'd50);
		t = $urandom;
		tx_idle   = 1'b0;
		long_hold = 300;
		for (i = 0; i < 12; i++) begin
			t = t + 32'($urandom_range(0, 40));
			send(mk_update(1'b1, t, pick_speed(), pick_speed(), pick_speed()));
		end
		send(mk_update(1'b0, t + 1, '0, '0, '0));
		// sender pause until the block has emptied
		wait_idle();
		tx_idle = 1'b1;
		send(mk_update(1'b1, t + 2, pick_speed(), pick_speed(), pick_speed()));
	endtask

	task automatic test_random_traffic();
		ctrl_update_t u;
		logic [31:0]  t;
		int           counted;
		int           phase;
		int           n;
		int           r;
		t = $urandom;
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: configure(16'($urandom), 16'($urandom_range(1, 3000)));
				1: configure(16'h000F, 16'hFFFF);
				2: configure(16'h0000, 16'h0001);
				default: configure(16'($urandom), 16'($urandom_range(0, 65535)));
			endcase
			counted = 0;
			while (counted < 70) begin
				if (counted % 35 == 0) begin
					tx_idle = $urandom_range(0, 3) != 0;
					rx_idle = $urandom_range(0, 3) != 0;
				end
				r = $urandom_range(0, 99);
				if (r < 8) begin
					u = mk_update(1'($urandom), $urandom, $urandom, $urandom, $urandom);
				end else begin
					case ($urandom_range(0, 9))
						0: t = t;
						1: t = t + 32'(cfg_refresh);
						2: t = t + 32'(cfg_refresh) + 1;
						3: t = t - 32'($urandom_range(1, 5000));
						4: t = $urandom;
						default: t = t + 32'($urandom_range(0, cfg_refresh / 3 + 2));
					endcase
					u = mk_update(1'b1, t, pick_speed(), pick_speed(), pick_speed());
					if (was_armed_q && $urandom_range(0, 9) == 0)
						u.armed = 1'b0;
					else if (!was_armed_q && $urandom_range(0, 3) == 0)
						u.armed = 1'b0;
				end
				send_update(u, n);
				if (n > 0)
					counted++;
			end
		end
		tx_idle = 1'b1;
		rx_idle = 1'b1;
	endtask

	initial begin : run_tests
		in_valid  = 1'b0;
		armed     = 1'b0;
		now_ms    = '0;
		speed_0   = '0;
		speed_1   = '0;
		speed_2   = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_FIRST_ID;
		cfg_data  = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_config_extremes();
		test_backpressure();
		test_random_traffic();
		wait_idle();
		if (expected_frames.size() != 0)
			report_error($sformatf("%0d frames never arrived", expected_frames.size()));
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// frame receiver: random stalls plus an occasional long hold-off
	initial begin : frame_sink
		int stall;
		int n;
		out_ready = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (long_hold > 0) begin
				n = long_hold;
				long_hold = 0;
				out_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			stall = rx_idle ? $urandom_range(0, 11) : 0;
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(negedge clk);
			while (!out_valid && long_hold == 0) @(negedge clk);
			@(posedge clk);
		end
	end

	// values seen at the falling edge are the ones taken at the next rising edge
	always @(negedge clk) begin : frame_check
		can_frame_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_frames.size() == 0) begin
				report_error($sformatf("unexpected frame id %h len %0d data %h last %b",
					frame_id, frame_len, frame_data, last_frame));
			end else begin
				want = expected_frames.pop_front();
				if (frame_id !== want.id || frame_len !== want.len ||
						frame_data !== want.data || last_frame !== want.last)
					report_error($sformatf({"frame mismatch: exp id %h len %0d data %h last %b,",
						" got id %h len %0d data %h last %b"}, want.id, want.len, want.data,
						want.last, frame_id, frame_len, frame_data, last_frame));
			end
		end
	end

endmodule
